FILE: src/gmss_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gmss_pkg
// Types and constants of the guarded motion session sequencer.
// ----------------------------------------------------------------------------
package gmss_pkg;

	// guard check periods, in guard checks
	localparam int unsigned WALL_PERIOD = 20;
	localparam int unsigned IMU_PERIOD  = 100;

	localparam logic [6:0]  WALL_RELOAD    = 7'(WALL_PERIOD - 1);
	localparam logic [6:0]  IMU_RELOAD     = 7'(IMU_PERIOD - 1);
	localparam logic [15:0] JUMP_LIMIT_RST = 16'd6000;

	localparam logic [2:0] PHASE_IDLE  = 3'd0;
	localparam logic [2:0] PHASE_FIRST = 3'd1;
	localparam logic [2:0] PHASE_LAST  = 3'd5;

	localparam int unsigned PADDR_W = 5;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_FWD   = 2'd1,
		PH_COAST = 2'd2,
		PH_SPIN  = 2'd3
	} phase_kind_t;

	typedef enum logic [2:0] {
		ABORT_NONE   = 3'd0,
		ABORT_SWITCH = 3'd1,
		ABORT_WALL   = 3'd2,
		ABORT_ENC    = 3'd3,
		ABORT_IMU    = 3'd4,
		ABORT_CANCEL = 3'd5
	} abort_t;

	typedef enum logic [2:0] {
		REG_RUN_MODE     = 3'd0,
		REG_SAFE_DUTY    = 3'd1,
		REG_FORWARD_TIME = 3'd2,
		REG_TURN_TIME    = 3'd3,
		REG_COAST_TIME   = 3'd4,
		REG_STEP_COUNT   = 3'd5,
		REG_JUMP_LIMIT   = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic               start_request;
		logic               stop_switch;
		logic signed [15:0] left_count;
		logic signed [15:0] right_count;
		logic               wall_healthy;
		logic               imu_healthy;
	} gmss_req_t;

	typedef struct packed {
		logic        motor_enable;
		logic        left_fwd;
		logic        right_fwd;
		logic [15:0] duty;
		logic [1:0]  phase_code;
		logic        busy_res;
		logic        finished;
		logic [2:0]  stop_cause;
	} gmss_res_t;

endpackage
`default_nettype wire

FILE: src/guarded_motion_session_sequencer_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// guarded_motion_session_sequencer_unit
// Timed motor phase sequencer with per-tick safety guard.
// ----------------------------------------------------------------------------
// One request is one millisecond tick and yields exactly one result. A request
// is taken into an input register, from which the session state is updated and
// the result is written into the output register, so the block sustains one
// request per clock while no result is stalled; a waiting result only holds the
// input register, and the block stalls requests only while both registers are
// full and the result is stalled. Registers are written over the APB port (word
// address = index); the user is to write them only while no request is in
// flight, which the block does not enforce. run_mode and the phase timing are
// read live by the sequencer. Search mode repeats forward/coast step_count
// times; shortest mode runs forward, coast, spin, coast, forward. A running tick
// checks stop switch, encoder jump, wall health (every 20th check) and IMU
// health (every 100th check), in that order; the first fault ends the session.
// ----------------------------------------------------------------------------
module guarded_motion_session_sequencer_unit
	import gmss_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_stall,
	input  wire gmss_req_t          req_data,
	output logic                    res_valid,
	input  wire logic               res_stall,
	output gmss_res_t               res_data,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	// configuration registers
	logic        run_mode_q;
	logic [15:0] safe_duty_q, forward_time_q, turn_time_q, coast_time_q;
	logic [15:0] step_count_q, jump_limit_q;

	// session state
	logic [2:0]  phase_idx_q;
	logic [15:0] phase_ticks_q, steps_done_q;
	logic [15:0] prev_left_q, prev_right_q;
	logic [6:0]  wall_cd_q, imu_cd_q;

	// input register and result register
	logic      valid_s1;
	gmss_req_t req_s1;
	logic      res_valid_q;
	gmss_res_t res_q;

	logic     out_free, step_s1;
	reg_idx_t reg_idx;

	assign pready    = 1'b1;
	assign reg_idx   = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign out_free  = !res_valid_q || !res_stall;
	assign step_s1   = valid_s1 && out_free;
	assign req_stall = valid_s1 && !out_free;
	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	// ---------------- configuration port ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_mode_q     <= 1'b0;
			safe_duty_q    <= '0;
			forward_time_q <= '0;
			turn_time_q    <= '0;
			coast_time_q   <= '0;
			step_count_q   <= '0;
			jump_limit_q   <= JUMP_LIMIT_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				REG_RUN_MODE:     run_mode_q     <= pwdata[0];
				REG_SAFE_DUTY:    safe_duty_q    <= pwdata[15:0];
				REG_FORWARD_TIME: forward_time_q <= pwdata[15:0];
				REG_TURN_TIME:    turn_time_q    <= pwdata[15:0];
				REG_COAST_TIME:   coast_time_q   <= pwdata[15:0];
				REG_STEP_COUNT:   step_count_q   <= pwdata[15:0];
				REG_JUMP_LIMIT:   jump_limit_q   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_RUN_MODE:     prdata = {31'd0, run_mode_q};
			REG_SAFE_DUTY:    prdata = {16'd0, safe_duty_q};
			REG_FORWARD_TIME: prdata = {16'd0, forward_time_q};
			REG_TURN_TIME:    prdata = {16'd0, turn_time_q};
			REG_COAST_TIME:   prdata = {16'd0, coast_time_q};
			REG_STEP_COUNT:   prdata = {16'd0, step_count_q};
			REG_JUMP_LIMIT:   prdata = {16'd0, jump_limit_q};
			default:          prdata = '0;
		endcase
	end

	// phase index decodes under the present mode; unreached indices act as coast
	function automatic phase_kind_t kind_of(input logic [2:0] idx, input logic mode);
		phase_kind_t k;
		if (idx == PHASE_IDLE)
			k = PH_IDLE;
		else if (!mode)
			k = (idx == 3'd1) ? PH_FWD : PH_COAST;
		else if (idx == 3'd1 || idx == 3'd5)
			k = PH_FWD;
		else if (idx == 3'd3)
			k = PH_SPIN;
		else
			k = PH_COAST;
		return k;
	endfunction

	// ---------------- guard check ----------------
	// On the start tick the guard runs against this tick's counts and with
	// both health checks due.
	logic               idle;
	logic [15:0]        base_left, base_right;
	logic [6:0]         base_wall_cd, base_imu_cd;
	logic signed [16:0] dl, dr;
	logic [16:0]        adl, adr;
	abort_t             g_reason;
	logic [15:0]        g_left, g_right;
	logic [6:0]         g_wall_cd, g_imu_cd;

	assign idle         = (phase_idx_q == PHASE_IDLE);
	assign base_left    = idle ? req_s1.left_count  : prev_left_q;
	assign base_right   = idle ? req_s1.right_count : prev_right_q;
	assign base_wall_cd = idle ? 7'd0 : wall_cd_q;
	assign base_imu_cd  = idle ? 7'd0 : imu_cd_q;

	always_comb begin
		dl  = {req_s1.left_count[15], req_s1.left_count} - {base_left[15], base_left};
		dr  = {req_s1.right_count[15], req_s1.right_count} - {base_right[15], base_right};
		adl = dl[16] ? 17'(-dl) : 17'(dl);
		adr = dr[16] ? 17'(-dr) : 17'(dr);

		g_reason  = ABORT_NONE;
		g_left    = base_left;
		g_right   = base_right;
		g_wall_cd = base_wall_cd;
		g_imu_cd  = base_imu_cd;
		if (req_s1.stop_switch) begin
			g_reason = ABORT_SWITCH;
		end else begin
			g_left  = req_s1.left_count;
			g_right = req_s1.right_count;
			if (adl > {1'b0, jump_limit_q} || adr > {1'b0, jump_limit_q}) begin
				g_reason = ABORT_ENC;
			end else begin
				if (base_wall_cd == 7'd0) begin
					g_wall_cd = WALL_RELOAD;
					if (!req_s1.wall_healthy) g_reason = ABORT_WALL;
				end else begin
					g_wall_cd = base_wall_cd - 7'd1;
				end
				// IMU is left untouched after a wall fault
				if (g_reason == ABORT_NONE) begin
					if (base_imu_cd == 7'd0) begin
						g_imu_cd = IMU_RELOAD;
						if (!req_s1.imu_healthy) g_reason = ABORT_IMU;
					end else begin
						g_imu_cd = base_imu_cd - 7'd1;
					end
				end
			end
		end
	end

	// ---------------- sequencer ----------------
	logic [2:0]  n_idx;
	logic [15:0] n_ticks, n_steps, n_left, n_right, ticks_inc, steps_inc;
	logic [15:0] cur_len_raw, cur_len;
	logic [6:0]  n_wall_cd, n_imu_cd;
	abort_t      reason;
	logic        ended;
	phase_kind_t cur_kind, new_kind;
	gmss_res_t   res_d;

	always_comb begin
		cur_kind = kind_of(phase_idx_q, run_mode_q);
		case (cur_kind)
			PH_FWD:  cur_len_raw = forward_time_q;
			PH_SPIN: cur_len_raw = turn_time_q;
			default: cur_len_raw = coast_time_q;
		endcase
		// a zero-length phase still lasts one tick
		cur_len   = (cur_len_raw == 16'd0) ? 16'd1 : cur_len_raw;
		ticks_inc = phase_ticks_q + 16'd1;
		steps_inc = steps_done_q + 16'd1;

		n_idx     = phase_idx_q;
		n_ticks   = phase_ticks_q;
		n_steps   = steps_done_q;
		n_left    = prev_left_q;
		n_right   = prev_right_q;
		n_wall_cd = wall_cd_q;
		n_imu_cd  = imu_cd_q;
		reason    = ABORT_NONE;
		ended     = 1'b0;

		if (idle) begin
			if (req_s1.start_request) begin
				if (req_s1.stop_switch) begin
					reason = ABORT_CANCEL;
				end else begin
					n_idx   = PHASE_FIRST;
					n_ticks = '0;
					n_steps = '0;
					n_left  = req_s1.left_count;
					n_right = req_s1.right_count;
					if (!run_mode_q && step_count_q == 16'd0) begin
						// empty search: ends at once, no guard check
						ended     = 1'b1;
						n_wall_cd = 7'd0;
						n_imu_cd  = 7'd0;
					end else begin
						n_wall_cd = g_wall_cd;
						n_imu_cd  = g_imu_cd;
						reason    = g_reason;
						ended     = (g_reason != ABORT_NONE);
					end
				end
			end
		end else begin
			n_left    = g_left;
			n_right   = g_right;
			n_wall_cd = g_wall_cd;
			n_imu_cd  = g_imu_cd;
			reason    = g_reason;
			if (g_reason != ABORT_NONE) begin
				ended = 1'b1;
			end else begin
				n_ticks = ticks_inc;
				if (ticks_inc >= cur_len) begin
					n_ticks = '0;
					if (!run_mode_q) begin
						if (phase_idx_q == 3'd1) begin
							n_idx = 3'd2;
						end else begin
							n_steps = steps_inc;
							if (steps_inc >= step_count_q) ended = 1'b1;
							else n_idx = PHASE_FIRST;
						end
					end else if (phase_idx_q >= PHASE_LAST) begin
						ended = 1'b1;
					end else begin
						n_idx = phase_idx_q + 3'd1;
					end
				end
			end
		end

		if (ended) begin
			n_idx   = PHASE_IDLE;
			n_ticks = '0;
			n_steps = '0;
		end

		new_kind           = kind_of(n_idx, run_mode_q);
		res_d.motor_enable = (new_kind == PH_FWD) || (new_kind == PH_SPIN);
		res_d.left_fwd     = 1'b1;
		res_d.right_fwd    = (new_kind != PH_SPIN);
		res_d.duty         = res_d.motor_enable ? safe_duty_q : 16'd0;
		res_d.phase_code   = new_kind;
		res_d.busy_res     = (n_idx != PHASE_IDLE);
		res_d.finished     = ended;
		res_d.stop_cause   = reason;
	end

	// ---------------- registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			res_valid_q   <= 1'b0;
			phase_idx_q   <= PHASE_IDLE;
			phase_ticks_q <= '0;
			steps_done_q  <= '0;
			prev_left_q   <= '0;
			prev_right_q  <= '0;
			wall_cd_q     <= '0;
			imu_cd_q      <= '0;
		end else begin
			if (!req_stall) valid_s1 <= req_valid;
			if (out_free) res_valid_q <= valid_s1;
			if (step_s1) begin
				phase_idx_q   <= n_idx;
				phase_ticks_q <= n_ticks;
				steps_done_q  <= n_steps;
				prev_left_q   <= n_left;
				prev_right_q  <= n_right;
				wall_cd_q     <= n_wall_cd;
				imu_cd_q      <= n_imu_cd;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) req_s1 <= req_data;
		if (step_s1) res_q <= res_d;
	end

endmodule
`default_nettype wire
